FILE: sv/pctd_pkg.sv
// Package for the prime counter by trial division.
// Holds the field widths, reset constants and start values shared by the top level.
// No dependencies.
package pctd_pkg;

  // Widths of the register and result fields
  localparam int LIMIT_W = 31;
  localparam int COUNT_W = 27;

  // Default limit width handed to the top level
  localparam int LIMIT_BITS_DEF = 31;

  // Limit after reset
  localparam logic [LIMIT_W-1:0] RESET_LIMIT = 31'd1000000000;

  // First candidate and first divisor
  localparam int FIRST_CAND = 2;
  localparam int FIRST_DIV  = 2;

endpackage

FILE: sv/prime_counter_trial_division_unit.sv
// Prime counter by trial division, top level.
// Depends on pctd_pkg for widths and reset constants.
//
// Usage:
//   Write upper_limit through upper_limit_wr_en while the block is idle; it
//   resets to 1000000000 (low LIMIT_BITS bits kept). A word on the input
//   channel (in_valid, in_stall, start_req) with start_req high counts the
//   primes n with 2 <= n < upper_limit and returns the count as one word on
//   the output channel (out_valid, out_stall, prime_count). A word with
//   start_req low returns the count of the last run (0 after reset) by way
//   of S_EMIT, where out_valid rises once the output register is free.
//   Each candidate passes through S_NEXT and S_CHECK; each divisor tried
//   adds a check in S_CHECK and a bit-serial remainder in S_DIVIDE that
//   takes one dividend bit per cycle; the run ends in S_EMIT. Candidates
//   are walked one after the other, so one request is in flight at a time;
//   in_stall is high from acceptance until the result is loaded into the
//   output register.
//   A new word may be accepted while the previous result still waits.
//   When the receiver stalls, the result holds in the output register and
//   a finished run waits for the register to free up.
//   Reset (rst, synchronous) clears the count, drops out_valid and returns
//   the sequencer to idle.
module prime_counter_trial_division_unit #(
  parameter int LIMIT_BITS = pctd_pkg::LIMIT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration
  input  logic                         upper_limit_wr_en,
  input  logic [LIMIT_BITS-1:0]        upper_limit,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         start_req,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pctd_pkg::COUNT_W-1:0] prime_count
);

  localparam int DIV_BITS = (LIMIT_BITS + 2) / 2;
  localparam int SQ_BITS  = 2 * DIV_BITS;
  localparam int REM_BITS = DIV_BITS + 1;
  localparam int CNT_BITS = $clog2(LIMIT_BITS + 1);
  localparam int COUNT_W  = pctd_pkg::COUNT_W;
  localparam logic [pctd_pkg::LIMIT_W-1:0] RESET_FULL = pctd_pkg::RESET_LIMIT;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_CHECK,
    S_DIVIDE,
    S_EMIT
  } state_t;

  state_t                state;
  logic [LIMIT_BITS-1:0] limit_reg;
  logic [LIMIT_BITS-1:0] candidate;
  logic [LIMIT_BITS-1:0] dividend;
  logic [DIV_BITS-1:0]   divisor;
  logic [SQ_BITS-1:0]    div_sq;
  logic [REM_BITS-1:0]   remainder;
  logic [CNT_BITS-1:0]   bit_cnt;
  logic [COUNT_W-1:0]    running_count;

  logic                  in_acc;
  logic                  out_free;
  logic [REM_BITS-1:0]   rem_shift;
  logic [REM_BITS-1:0]   rem_next;
  logic [SQ_BITS-1:0]    sq_next;
  logic [SQ_BITS-1:0]    cand_ext;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // One restoring-division step: bring in the next dividend bit
  assign rem_shift = {remainder[REM_BITS-2:0], dividend[LIMIT_BITS-1]};
  assign rem_next  = (rem_shift >= {1'b0, divisor}) ?
                     (rem_shift - {1'b0, divisor}) : rem_shift;

  // (d+1)^2 = d^2 + 2d + 1
  assign sq_next  = div_sq + {{(SQ_BITS-DIV_BITS-1){1'b0}}, divisor, 1'b1};
  assign cand_ext = {{(SQ_BITS-LIMIT_BITS){1'b0}}, candidate};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= RESET_FULL[LIMIT_BITS-1:0];
    end else if (upper_limit_wr_en) begin
      limit_reg <= upper_limit;
    end
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_count <= '0;
      out_valid     <= 1'b0;
      candidate     <= '0;
      divisor       <= '0;
    end else begin
      // Drop the word once taken, unless a new one is loaded below
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (start_req) begin
              candidate     <= LIMIT_BITS'(pctd_pkg::FIRST_CAND);
              running_count <= '0;
              state         <= S_NEXT;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        // Start trials on a candidate, or finish at the limit
        S_NEXT: begin
          if (candidate >= limit_reg) begin
            state <= S_EMIT;
          end else begin
            divisor <= DIV_BITS'(pctd_pkg::FIRST_DIV);
            div_sq  <= SQ_BITS'(pctd_pkg::FIRST_DIV * pctd_pkg::FIRST_DIV);
            state   <= S_CHECK;
          end
        end
        // Divisor past the square root: candidate is prime; else start a remainder
        S_CHECK: begin
          if (div_sq > cand_ext) begin
            running_count <= running_count + COUNT_W'(1);
            candidate     <= candidate + LIMIT_BITS'(1);
            state         <= S_NEXT;
          end else begin
            remainder <= '0;
            dividend  <= candidate;
            bit_cnt   <= CNT_BITS'(LIMIT_BITS);
            state     <= S_DIVIDE;
          end
        end
        // Bit-serial remainder, one dividend bit per cycle
        S_DIVIDE: begin
          remainder <= rem_next;
          dividend  <= {dividend[LIMIT_BITS-2:0], 1'b0};
          bit_cnt   <= bit_cnt - CNT_BITS'(1);
          if (bit_cnt == CNT_BITS'(1)) begin
            if (rem_next == '0) begin
              candidate <= candidate + LIMIT_BITS'(1);
              state     <= S_NEXT;
            end else begin
              divisor <= divisor + DIV_BITS'(1);
              div_sq  <= sq_next;
              state   <= S_CHECK;
            end
          end
        end
        // Load the result once the output register is free
        S_EMIT: begin
          if (out_free) begin
            prime_count <= running_count;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
